// ===== sv/sat_pkg.sv =====
// Shared types, codes, transition tables and helper functions for the shell argument tokenizer.
package sat_pkg;

    // Input transaction payload
    typedef struct packed {
        logic [7:0] ch;
        logic       restart;
    } tok_in_t;

    // Result transaction payload
    typedef struct packed {
        logic [3:0] action;
        logic [7:0] out_char;
        logic [5:0] next_state;
        logic [2:0] error_code;
        logic       var_dropped;
        logic       ignored;
    } tok_res_t;

    // Action codes
    typedef enum logic [3:0] {
        ACT_STORE_ARG    = 4'd0,
        ACT_FLUSH_ARG    = 4'd1,
        ACT_STORE_VAR    = 4'd2,
        ACT_LOOKUP       = 4'd3,
        ACT_LOOKUP_FLUSH = 4'd4,
        ACT_SKIP         = 4'd5,
        ACT_ESCAPE       = 4'd6,
        ACT_LOOKUP_STORE = 4'd7,
        ACT_ERROR        = 4'd8
    } action_t;

    // Byte classes
    typedef enum logic [3:0] {
        CLS_END    = 4'd0,
        CLS_DQUOTE = 4'd1,
        CLS_APOS   = 4'd2,
        CLS_LBRACE = 4'd3,
        CLS_RBRACE = 4'd4,
        CLS_DOLLAR = 4'd5,
        CLS_BSLASH = 4'd6,
        CLS_NAME   = 4'd7,
        CLS_SPACE  = 4'd8,
        CLS_OTHER  = 4'd9
    } char_class_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_MODE        = 1'b0,
        CFG_START_STATE = 1'b1
    } cfg_index_t;

    localparam int NUM_MODES   = 2;
    localparam int NUM_ROWS    = 15;
    localparam int NUM_CLASSES = 10;

    localparam logic [3:0] MAX_START_STATE = 4'd14;
    localparam logic [5:0] STATE_RUN_LIMIT = 6'd15;
    localparam logic [5:0] STATE_FINAL     = 6'd32;
    localparam logic [5:0] STATE_ERR_FIRST = 6'd33;
    localparam logic [5:0] STATE_ERR_LAST  = 6'd37;

    // Action table: [mode][state][class]
    localparam logic [3:0] ACT_TAB [NUM_MODES][NUM_ROWS][NUM_CLASSES] = '{
        '{
            '{4'd5, 4'd5, 4'd5, 4'd0, 4'd0, 4'd5, 4'd5, 4'd0, 4'd5, 4'd0},
            '{4'd1, 4'd5, 4'd5, 4'd0, 4'd0, 4'd5, 4'd5, 4'd0, 4'd1, 4'd0},
            '{4'd8, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd5, 4'd4, 4'd0, 4'd0, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd6, 4'd0, 4'd0},
            '{4'd8, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8, 4'd2, 4'd8, 4'd8},
            '{4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2, 4'd2, 4'd2, 4'd2},
            '{4'd8, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3, 4'd2},
            '{4'd8, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8, 4'd2, 4'd8, 4'd8},
            '{4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2, 4'd2, 4'd2, 4'd2},
            '{4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd8, 4'd2, 4'd2, 4'd3, 4'd7},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
        },
        '{
            '{4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd8, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8, 4'd2, 4'd8, 4'd8},
            '{4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2, 4'd2, 4'd2, 4'd2},
            '{4'd8, 4'd7, 4'd7, 4'd7, 4'd7, 4'd3, 4'd7, 4'd2, 4'd7, 4'd2},
            '{4'd8, 4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd8, 4'd2, 4'd8, 4'd8},
            '{4'd8, 4'd8, 4'd8, 4'd8, 4'd3, 4'd8, 4'd2, 4'd2, 4'd2, 4'd2},
            '{4'd4, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8, 4'd2, 4'd2, 4'd7, 4'd7},
            '{4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8}
        }
    };

    // Next-state table: [mode][state][class]
    localparam logic [5:0] NEXT_TAB [NUM_MODES][NUM_ROWS][NUM_CLASSES] = '{
        '{
            '{6'd32, 6'd4,  6'd2,  6'd1,  6'd1,  6'd11, 6'd14, 6'd1,  6'd0,  6'd1 },
            '{6'd32, 6'd4,  6'd2,  6'd1,  6'd1,  6'd11, 6'd14, 6'd1,  6'd0,  6'd1 },
            '{6'd33, 6'd2,  6'd1,  6'd2,  6'd2,  6'd2,  6'd3,  6'd2,  6'd2,  6'd2 },
            '{6'd33, 6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2 },
            '{6'd34, 6'd1,  6'd0,  6'd4,  6'd4,  6'd8,  6'd7,  6'd4,  6'd4,  6'd4 },
            '{6'd33, 6'd5,  6'd4,  6'd5,  6'd5,  6'd5,  6'd6,  6'd5,  6'd5,  6'd5 },
            '{6'd33, 6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5 },
            '{6'd34, 6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd5 },
            '{6'd34, 6'd34, 6'd34, 6'd9,  6'd34, 6'd34, 6'd34, 6'd10, 6'd34, 6'd34},
            '{6'd36, 6'd36, 6'd36, 6'd36, 6'd4,  6'd36, 6'd9,  6'd9,  6'd9,  6'd9 },
            '{6'd34, 6'd1,  6'd4,  6'd4,  6'd4,  6'd8,  6'd4,  6'd10, 6'd4,  6'd10},
            '{6'd35, 6'd35, 6'd35, 6'd12, 6'd35, 6'd35, 6'd35, 6'd13, 6'd35, 6'd35},
            '{6'd36, 6'd36, 6'd36, 6'd36, 6'd1,  6'd35, 6'd12, 6'd12, 6'd12, 6'd12},
            '{6'd32, 6'd4,  6'd2,  6'd1,  6'd1,  6'd35, 6'd13, 6'd13, 6'd1,  6'd1 },
            '{6'd37, 6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1,  6'd1 }
        },
        '{
            '{6'd32, 6'd4,  6'd2,  6'd0,  6'd0,  6'd11, 6'd1,  6'd0,  6'd0,  6'd0 },
            '{6'd37, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0 },
            '{6'd33, 6'd2,  6'd0,  6'd2,  6'd2,  6'd2,  6'd3,  6'd2,  6'd2,  6'd2 },
            '{6'd33, 6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2,  6'd2 },
            '{6'd34, 6'd0,  6'd4,  6'd4,  6'd4,  6'd8,  6'd7,  6'd4,  6'd4,  6'd4 },
            '{6'd33, 6'd5,  6'd4,  6'd5,  6'd5,  6'd5,  6'd6,  6'd5,  6'd5,  6'd5 },
            '{6'd33, 6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5,  6'd5 },
            '{6'd34, 6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4,  6'd4 },
            '{6'd34, 6'd34, 6'd34, 6'd9,  6'd35, 6'd35, 6'd35, 6'd10, 6'd35, 6'd35},
            '{6'd36, 6'd36, 6'd36, 6'd36, 6'd4,  6'd35, 6'd9,  6'd9,  6'd9,  6'd9 },
            '{6'd34, 6'd0,  6'd4,  6'd4,  6'd4,  6'd8,  6'd4,  6'd10, 6'd4,  6'd10},
            '{6'd35, 6'd35, 6'd35, 6'd12, 6'd35, 6'd35, 6'd35, 6'd13, 6'd35, 6'd35},
            '{6'd36, 6'd36, 6'd36, 6'd36, 6'd0,  6'd35, 6'd12, 6'd12, 6'd12, 6'd12},
            '{6'd32, 6'd4,  6'd2,  6'd0,  6'd0,  6'd35, 6'd13, 6'd13, 6'd0,  6'd0 },
            '{6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32}
        }
    };

    // Sort a byte into its class
    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t cls;
        if (c == 8'h00)
            cls = CLS_END;
        else if (c == "\"")
            cls = CLS_DQUOTE;
        else if (c == 8'h27)
            cls = CLS_APOS;
        else if (c == "{")
            cls = CLS_LBRACE;
        else if (c == "}")
            cls = CLS_RBRACE;
        else if (c == "$")
            cls = CLS_DOLLAR;
        else if (c == "\\")
            cls = CLS_BSLASH;
        else if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                 (c >= "A" && c <= "Z") || c == "_")
            cls = CLS_NAME;
        else if (c == " " || (c >= 8'd9 && c <= 8'd13))
            cls = CLS_SPACE;
        else
            cls = CLS_OTHER;
        return cls;
    endfunction

    // Translate the letter after a backslash into its control code
    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            "a":     r = 8'd7;
            "b":     r = 8'd8;
            "n":     r = 8'd10;
            "r":     r = 8'd13;
            "t":     r = 8'd9;
            "v":     r = 8'd11;
            default: r = c;
        endcase
        return r;
    endfunction

    // Error code carried by an error state, zero otherwise
    function automatic logic [2:0] err_of(input logic [5:0] s);
        logic [5:0] d;
        d = s - STATE_FINAL;
        return (s >= STATE_ERR_FIRST && s <= STATE_ERR_LAST) ? d[2:0] : 3'd0;
    endfunction

endpackage

// ===== sv/sat_step.sv =====
// Per-byte transition logic: restart rule, table lookup, escape and name-length update.
module sat_step
    import sat_pkg::*;
#(
    parameter int VAR_LIMIT = 128
)
(
    input  tok_in_t    item,
    input  logic [5:0] state,
    input  logic [7:0] var_len,
    input  logic       mode,
    input  logic [3:0] start_state,
    output tok_res_t   result,
    output logic [5:0] state_next,
    output logic [7:0] var_len_next
);

    localparam logic [7:0] LIMIT = 8'(VAR_LIMIT);

    logic [5:0]  st;
    logic [3:0]  row;
    char_class_t cls;
    action_t     act;
    logic [5:0]  nxt;

    // Restart loads the start state unless an error state holds
    always_comb
    begin
        st = state;
        if (item.restart && state <= STATE_FINAL)
        begin
            st = (start_state > MAX_START_STATE) ? {2'b00, MAX_START_STATE}
                                                 : {2'b00, start_state};
        end
    end

    // Table lookup
    assign row = st[3:0];
    assign cls = classify(item.ch);
    assign act = action_t'(ACT_TAB[mode][row][cls]);
    assign nxt = NEXT_TAB[mode][row][cls];

    // Result and state update
    always_comb
    begin
        result       = '0;
        state_next   = st;
        var_len_next = var_len;
        if (st >= STATE_RUN_LIMIT)
        begin
            // halted: byte skipped, state held
            result.action     = ACT_SKIP;
            result.next_state = st;
            result.error_code = err_of(st);
            result.ignored    = 1'b1;
        end
        else
        begin
            result.action     = act;
            result.next_state = nxt;
            result.error_code = err_of(nxt);
            state_next        = nxt;
            unique case (act)
                ACT_STORE_ARG:
                    result.out_char = item.ch;
                ACT_STORE_VAR:
                begin
                    result.out_char = item.ch;
                    if (var_len >= LIMIT)
                        result.var_dropped = 1'b1;
                    else
                        var_len_next = var_len + 8'd1;
                end
                ACT_LOOKUP, ACT_LOOKUP_FLUSH:
                    var_len_next = '0;
                ACT_ESCAPE:
                    result.out_char = escape_byte(item.ch);
                ACT_LOOKUP_STORE:
                begin
                    result.out_char = item.ch;
                    var_len_next    = '0;
                end
                default:
                    result.out_char = '0;
            endcase
        end
    end

endmodule

// ===== sv/shell_argument_tokenizer.sv =====
// Path: input register, then result register; the result register loads when the byte fires.
// Throughput: one byte per cycle unless results stall; tok_ready follows res_ready combinationally,
// so a stalled result blocks input in the same cycle once the input register is full.
// The parser state feeds back through one table lookup per cycle, so every byte
// sees the state left by the byte before it with no stall.
// Reset clears mode, start_state, parser state, name length and both valid flags.
module shell_argument_tokenizer
    import sat_pkg::*;
#(
    parameter int VAR_LIMIT = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  tok_in_t    tok_data,
    output logic       res_valid,
    input  logic       res_ready,
    output tok_res_t   res_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    logic       mode_reg;
    logic [3:0] start_state_reg;
    logic [5:0] state_reg;
    logic [7:0] var_len_reg;
    logic       inq_valid_reg;
    tok_in_t    inq_reg;
    logic       res_valid_reg;
    tok_res_t   res_reg;

    tok_res_t   result_next;
    logic [5:0] state_next;
    logic [7:0] var_len_next;
    logic       fire;

    // Handshakes
    assign fire      = inq_valid_reg && (!res_valid_reg || res_ready);
    assign tok_ready = !inq_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            start_state_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODE:        mode_reg        <= cfg_data[0];
                CFG_START_STATE: start_state_reg <= cfg_data;
                default:         mode_reg        <= mode_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inq_valid_reg <= 1'b0;
        else if (tok_ready)
            inq_valid_reg <= tok_valid;
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid && tok_ready)
            inq_reg <= tok_data;
    end

    // Transition logic
    sat_step #(
        .VAR_LIMIT (VAR_LIMIT)
    ) u_step (
        .item         (inq_reg),
        .state        (state_reg),
        .var_len      (var_len_reg),
        .mode         (mode_reg),
        .start_state  (start_state_reg),
        .result       (result_next),
        .state_next   (state_next),
        .var_len_next (var_len_next)
    );

    // Parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            var_len_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg     <= state_next;
                var_len_reg   <= var_len_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
            res_reg <= result_next;
    end

    // The stored state always matches the state reported with the latest result
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> state_reg == res_reg.next_state)
        else $error("parser state differs from reported next_state");

    // Error code is set exactly for error states
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((res_reg.error_code != 3'd0) ==
            (res_reg.next_state >= STATE_ERR_FIRST && res_reg.next_state <= STATE_ERR_LAST)))
        else $error("error_code inconsistent with next_state");

    // Name length never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        var_len_reg <= 8'(VAR_LIMIT))
        else $error("variable name length above limit");

    // A skipped byte on a halted machine touches nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.ignored) |->
            (res_reg.action == ACT_SKIP && !res_reg.var_dropped && res_reg.out_char == 8'd0))
        else $error("ignored byte produced side effects");

    // An error state holds across further bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && state_reg >= STATE_ERR_FIRST) |=> state_reg == $past(state_reg))
        else $error("error state left without reset");

endmodule

// ===== test/shell_argument_tokenizer_tb.sv =====
// Self-checking testbench for the shell argument tokenizer: directed and random byte streams.
module testbench;
    import sat_pkg::*;

    localparam int         NAME_LIMIT  = 128;
    localparam logic [5:0] HALT_FROM   = 6'd15;
    localparam logic [5:0] LAST_ROW    = 6'd14;
    localparam logic [5:0] FINAL_STATE = 6'd32;
    localparam logic [5:0] FAULT_LO    = 6'd33;
    localparam logic [5:0] FAULT_HI    = 6'd37;
    localparam logic [47:0] ESC_KEYS   = "abnrtv";

    // Action map, one letter per byte class (end, dquote, apos, {, }, $, \, name, space, other).
    // A store arg, F flush, V store var, L lookup, K lookup+flush, S skip, E escape,
    // M lookup+store, X error.
    localparam logic [79:0] ACT_ROWS [2][15] = '{
        '{"SSSAASSASA", "FSSAASSAFA", "XASAAASAAA", "XAAAAAAAAA", "XSKAASSAAA",
          "XASAAASAAA", "XAAAAAAAAA", "XAAAAAAEAA", "XXXSXXXVXX", "XXXXLXVVVV",
          "XLLLLLLVLV", "XXXSXXXVXX", "XXXXLXVVVV", "KLLLLXVVLM", "XAAAAAAAAA"},
        '{"FAAAASSAAA", "XAAAAAAAAA", "XAAAAAAAAA", "XAAAAAAAAA", "XAAAASAAAA",
          "XAAAAAAAAA", "XAAAAAAAAA", "XAAAAAAAAA", "XXXSXXXVXX", "XXXXLXVVVV",
          "XMMMMLMVMV", "XXXSXXXVXX", "XXXXLXVVVV", "KMMMMXVVMM", "XXXXXXXXXX"}
    };

    // Successor state per mode, state and byte class
    localparam int NEXT_ROWS [2][15][10] = '{
        '{
            '{32,  4,  2,  1,  1, 11, 14,  1,  0,  1},
            '{32,  4,  2,  1,  1, 11, 14,  1,  0,  1},
            '{33,  2,  1,  2,  2,  2,  3,  2,  2,  2},
            '{33,  2,  2,  2,  2,  2,  2,  2,  2,  2},
            '{34,  1,  0,  4,  4,  8,  7,  4,  4,  4},
            '{33,  5,  4,  5,  5,  5,  6,  5,  5,  5},
            '{33,  5,  5,  5,  5,  5,  5,  5,  5,  5},
            '{34,  4,  4,  4,  4,  4,  4,  4,  4,  5},
            '{34, 34, 34,  9, 34, 34, 34, 10, 34, 34},
            '{36, 36, 36, 36,  4, 36,  9,  9,  9,  9},
            '{34,  1,  4,  4,  4,  8,  4, 10,  4, 10},
            '{35, 35, 35, 12, 35, 35, 35, 13, 35, 35},
            '{36, 36, 36, 36,  1, 35, 12, 12, 12, 12},
            '{32,  4,  2,  1,  1, 35, 13, 13,  1,  1},
            '{37,  1,  1,  1,  1,  1,  1,  1,  1,  1}
        },
        '{
            '{32,  4,  2,  0,  0, 11,  1,  0,  0,  0},
            '{37,  0,  0,  0,  0,  0,  0,  0,  0,  0},
            '{33,  2,  0,  2,  2,  2,  3,  2,  2,  2},
            '{33,  2,  2,  2,  2,  2,  2,  2,  2,  2},
            '{34,  0,  4,  4,  4,  8,  7,  4,  4,  4},
            '{33,  5,  4,  5,  5,  5,  6,  5,  5,  5},
            '{33,  5,  5,  5,  5,  5,  5,  5,  5,  5},
            '{34,  4,  4,  4,  4,  4,  4,  4,  4,  4},
            '{34, 34, 34,  9, 35, 35, 35, 10, 35, 35},
            '{36, 36, 36, 36,  4, 35,  9,  9,  9,  9},
            '{34,  0,  4,  4,  4,  8,  4, 10,  4, 10},
            '{35, 35, 35, 12, 35, 35, 35, 13, 35, 35},
            '{36, 36, 36, 36,  0, 35, 12, 12, 12, 12},
            '{32,  4,  2,  0,  0, 35, 13, 13,  0,  0},
            '{32, 32, 32, 32, 32, 32, 32, 32, 32, 32}
        }
    };

    // Tokenizer prediction plus the queue of results still due
    class tok_scoreboard;
        logic       mode_sel;
        logic [3:0] start_reg;
        logic [5:0] parse_state;
        logic [7:0] name_len;
        tok_res_t   due_results[$];
        int         mismatches;

        function new();
            mode_sel    = 1'b0;
            start_reg   = 4'd0;
            parse_state = 6'd0;
            name_len    = 8'd0;
            mismatches  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [3:0] value);
            if (idx == CFG_MODE)
                mode_sel = value[0];
            else
                start_reg = value;
        endfunction

        function logic [2:0] fault_code(logic [5:0] s);
            logic [5:0] d;
            d = s - FINAL_STATE;
            return (s >= FAULT_LO && s <= FAULT_HI) ? d[2:0] : 3'd0;
        endfunction

        function char_class_t class_of(logic [7:0] c);
            case (c)
                8'h00:                               return CLS_END;
                "\"":                                return CLS_DQUOTE;
                "'":                                 return CLS_APOS;
                "{":                                 return CLS_LBRACE;
                "}":                                 return CLS_RBRACE;
                "$":                                 return CLS_DOLLAR;
                "\\":                                return CLS_BSLASH;
                "_":                                 return CLS_NAME;
                " ", 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return CLS_SPACE;
                default: ;
            endcase
            if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]})
                return CLS_NAME;
            return CLS_OTHER;
        endfunction

        function action_t letter_action(logic [7:0] l);
            case (l)
                "A":     return ACT_STORE_ARG;
                "F":     return ACT_FLUSH_ARG;
                "V":     return ACT_STORE_VAR;
                "L":     return ACT_LOOKUP;
                "K":     return ACT_LOOKUP_FLUSH;
                "S":     return ACT_SKIP;
                "E":     return ACT_ESCAPE;
                "M":     return ACT_LOOKUP_STORE;
                default: return ACT_ERROR;
            endcase
        endfunction

        // backslash letters become control codes, anything else passes
        function logic [7:0] unescape(logic [7:0] c);
            case (c)
                "a":     return 8'h07;
                "b":     return 8'h08;
                "n":     return 8'h0A;
                "r":     return 8'h0D;
                "t":     return 8'h09;
                "v":     return 8'h0B;
                default: return c;
            endcase
        endfunction

        // Result of one byte, state left untouched
        function tok_res_t predict(tok_in_t t);
            tok_res_t    r;
            logic [5:0]  s;
            char_class_t cls;
            action_t     act;
            int          m;
            s = parse_state;
            m = int'(mode_sel);
            r = '0;
            if (t.restart && s <= FINAL_STATE)
                s = (start_reg > LAST_ROW[3:0]) ? LAST_ROW : {2'b00, start_reg};
            // halted: byte skipped, state reported as is
            if (s >= HALT_FROM) begin
                r.action     = ACT_SKIP;
                r.next_state = s;
                r.error_code = fault_code(s);
                r.ignored    = 1'b1;
                return r;
            end
            cls = class_of(t.ch);
            act = letter_action(ACT_ROWS[m][s][79 - 8 * int'(cls) -: 8]);
            r.action     = act;
            r.next_state = 6'(NEXT_ROWS[m][s][int'(cls)]);
            r.error_code = fault_code(r.next_state);
            case (act)
                ACT_STORE_ARG, ACT_LOOKUP_STORE: r.out_char = t.ch;
                ACT_ESCAPE:                      r.out_char = unescape(t.ch);
                ACT_STORE_VAR:
                begin
                    r.out_char    = t.ch;
                    r.var_dropped = (name_len >= NAME_LIMIT);
                end
                default: ;
            endcase
            return r;
        endfunction

        // Predict and commit the state change
        function tok_res_t advance(tok_in_t t);
            tok_res_t r;
            r = predict(t);
            parse_state = r.next_state;
            case (action_t'(r.action))
                ACT_STORE_VAR:
                begin
                    if (!r.var_dropped)
                        name_len = name_len + 8'd1;
                end
                ACT_LOOKUP, ACT_LOOKUP_FLUSH, ACT_LOOKUP_STORE: name_len = 8'd0;
                default: ;
            endcase
            return r;
        endfunction

        function void note_input(tok_in_t t);
            due_results.push_back(advance(t));
        endfunction

        function void field_diff(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(tok_res_t got);
            tok_res_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                return;
            end
            want = due_results.pop_front();
            field_diff("action", want.action, got.action);
            field_diff("out_char", want.out_char, got.out_char);
            field_diff("next_state", want.next_state, got.next_state);
            field_diff("error_code", want.error_code, got.error_code);
            field_diff("var_dropped", want.var_dropped, got.var_dropped);
            field_diff("ignored", want.ignored, got.ignored);
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       tok_valid = 1'b0;
    logic       tok_ready;
    tok_in_t    tok_data  = '0;
    logic       res_valid;
    logic       res_ready = 1'b0;
    tok_res_t   res_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_index = 1'b0;
    logic [3:0] cfg_data  = 4'd0;

    tok_scoreboard sb        = new();
    tok_scoreboard lookahead = new();
    int            live_bytes = 0;
    bit            tx_steady  = 1'b0;
    bit            rx_steady  = 1'b0;

    shell_argument_tokenizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watch all three channels
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
            if (tok_valid && tok_ready)
                sb.note_input(tok_data);
            if (res_valid && res_ready)
                sb.check_result(res_data);
        end
    end

    // Result side: random stall before each transaction
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) @(posedge clk);
        end
    end

    // Valid stays high across back-to-back transactions
    task automatic send_byte(input logic [7:0] c, input logic r);
        tok_in_t  t;
        tok_res_t fore;
        int       gap;
        t.ch      = c;
        t.restart = r;
        if ($urandom_range(0, 63) == 0)
            tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            tok_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok_valid <= 1'b1;
        tok_data  <= t;
        @(posedge clk);
        while (!tok_ready) @(posedge clk);
        fore = lookahead.advance(t);
        if (!fore.ignored)
            live_bytes++;
    endtask

    task automatic wait_idle();
        tok_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_results.size() != 0) @(posedge clk);
    endtask

    // Both registers in one burst, valid held between them
    task automatic set_config(input logic m, input logic [3:0] s);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data  <= {3'b000, m};
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        lookahead.write_reg(CFG_MODE, {3'b000, m});
        cfg_index <= CFG_START_STATE;
        cfg_data  <= s;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        lookahead.write_reg(CFG_START_STATE, s);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] name_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h30, 8'h39));
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            2:       return 8'($urandom_range(8'h61, 8'h7A));
            default: return "_";
        endcase
    endfunction

    // Byte biased toward the classes that steer the parser
    function automatic logic [7:0] any_byte();
        int k;
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return "\"";
            2:       return "'";
            3:       return "{";
            4:       return "}";
            5:       return "$";
            6:       return "\\";
            7, 8:    return name_byte();
            9:
            begin
                k = $urandom_range(0, 5);
                return ESC_KEYS[8 * k +: 8];
            end
            10:
            begin
                k = $urandom_range(8, 13);
                return (k == 8) ? " " : 8'(k);
            end
            11:      return 8'($urandom_range(128, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One random transaction, or a long name run, that keeps the parser out of its fault states
    task automatic random_step();
        tok_in_t t;
        logic    r;
        int      tries;
        if (lookahead.parse_state inside {6'd9, 6'd10, 6'd12, 6'd13} &&
            $urandom_range(0, 79) == 0) begin
            // long variable name, which may run past the name limit
            repeat ($urandom_range(120, 140)) send_byte(name_byte(), 1'b0);
        end
        else begin
            if (lookahead.parse_state == FINAL_STATE)
                r = ($urandom_range(0, 3) != 0);
            else
                r = ($urandom_range(0, 11) == 0);
            t.restart = r;
            tries = 0;
            do begin
                t.ch = any_byte();
                tries++;
            end while (lookahead.fault_code(lookahead.predict(t).next_state) != 0 && tries < 40);
            if (lookahead.fault_code(lookahead.predict(t).next_state) != 0)
                t.ch = "a";
            send_byte(t.ch, r);
        end
    endtask

    initial
    begin
        int phase;
        int target;
        int spent;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk in reset configuration (command line mode, start 0)
        send_byte("h", 1'b1);
        send_byte(8'hFF, 1'b0);     // high byte counts as other
        send_byte(8'h09, 1'b0);     // tab flushes the word
        send_byte("\"", 1'b0);
        send_byte("\\", 1'b0);
        send_byte("n", 1'b0);       // escaped letter inside quotes
        send_byte("'", 1'b0);       // apostrophe in quotes: lookup+flush
        send_byte("$", 1'b0);
        send_byte("{", 1'b0);
        send_byte("Z", 1'b0);
        send_byte("}", 1'b0);
        send_byte("$", 1'b0);
        send_byte("_", 1'b0);
        send_byte("-", 1'b0);       // ends bare name: lookup+store
        send_byte("'", 1'b0);
        send_byte("\\", 1'b0);
        send_byte("x", 1'b0);
        send_byte("'", 1'b0);
        send_byte("\\", 1'b0);
        send_byte("!", 1'b0);
        send_byte(8'h00, 1'b0);     // end of string: final state
        send_byte("a", 1'b0);       // halted, byte ignored
        send_byte("a", 1'b1);       // restart out of final state
        wait_idle();

        // Random phases, each with its own configuration
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       set_config(1'b1, 4'd14);
                1:       set_config(1'b0, 4'd15);
                2:       set_config(1'b1, 4'd0);
                3:       set_config(1'b0, 4'd0);
                default: set_config(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
            endcase
            target = live_bytes + ((phase < 2) ? 60 : 255);
            while (live_bytes < target) begin
                random_step();
                if ($urandom_range(0, 199) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        // Fault states hold until reset, so drive into one only at the very end
        spent = 0;
        while (lookahead.fault_code(lookahead.parse_state) == 0 && spent < 300) begin
            send_byte(any_byte(), $urandom_range(0, 3) == 0);
            spent++;
        end
        repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_idle();
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.due_results.size() == 0)
            $display("shell_argument_tokenizer test passed");
        else
            $display("shell_argument_tokenizer test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8000000;
        $display("shell_argument_tokenizer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sat_pkg.sv
sv/sat_step.sv
sv/shell_argument_tokenizer.sv
test/shell_argument_tokenizer_tb.sv
